// ----- sv/acf_pkg.sv -----
// Shared types, codes and constants for the alignment column filter.
package acf_pkg;

  localparam int MAX_COLUMNS = 65536;
  localparam int MAX_RECORDS = 65535;
  localparam int ADDR_W      = $clog2(MAX_COLUMNS);
  localparam int COL_W       = ADDR_W + 1;
  localparam int RC_W        = $clog2(MAX_RECORDS + 1);
  localparam int TALLY_W     = 16;
  localparam int LIMIT_W     = 14;
  localparam int COUNT_W     = 17;
  localparam int PROD_W      = LIMIT_W + RC_W;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(500);
  localparam logic [LIMIT_W-1:0] SCALE       = LIMIT_W'(10000);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [TALLY_W-1:0] TALLY_MAX   = {TALLY_W{1'b1}};

  // Operation codes on the command port
  localparam logic [2:0] OP_LOAD_SYM  = 3'd0;
  localparam logic [2:0] OP_LOAD_HDR  = 3'd1;
  localparam logic [2:0] OP_EVALUATE  = 3'd2;
  localparam logic [2:0] OP_FILT_SYM  = 3'd3;
  localparam logic [2:0] OP_FILT_HDR  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_LIMIT    = 2'd0;
  localparam logic [1:0] REG_STRICT   = 2'd1;
  localparam logic [1:0] REG_SNP      = 2'd2;
  localparam logic [1:0] REG_CONST    = 2'd3;

  // Alignment characters
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_GAP  = 8'h2D;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_G    = 8'h47;

  typedef struct packed {
    logic [LIMIT_W-1:0] invalid_limit;
    logic               drop_invalid;
    logic               snp_only;
    logic               report_constant;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] sym;
    logic       invalid;
    logic [3:0] base;     // one-hot A T C G from bit 0
  } item_t;

endpackage

// ----- sv/acf_front.sv -----
// Front end: accepts commands, classifies symbols and queues items for the back end.
module acf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         operation,
  input  logic [7:0]         symbol,
  output logic               busy,
  output logic               q_valid,
  output acf_pkg::item_t     q_item,
  input  logic               q_take
);
  import acf_pkg::*;

  item_t               q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wp;
  logic [QPTR_W-1:0]   rp;
  logic [QPTR_W:0]     count;
  item_t               dec;
  logic                useful;
  logic                push;

  // Classify the incoming symbol
  always_comb begin
    dec.op      = operation;
    dec.sym     = symbol;
    dec.invalid = (symbol == CH_N) || (symbol == CH_GAP);
    dec.base    = {symbol == CH_G, symbol == CH_C, symbol == CH_T, symbol == CH_A};
    useful      = (operation == OP_LOAD_SYM) || (operation == OP_LOAD_HDR) ||
                  (operation == OP_EVALUATE) || (operation == OP_FILT_SYM) ||
                  (operation == OP_FILT_HDR);
  end

  assign busy    = (count == (QPTR_W+1)'(QDEPTH));
  assign push    = start && !busy && useful;
  assign q_valid = (count != '0);
  assign q_item  = q_mem[rp];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp] <= dec;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (q_take) rp <= rp + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_take);
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("queue read while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");
  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (push && !q_take) |=> (count == $past(count) + 1'b1)) else $error("push lost");

endmodule

// ----- sv/acf_back.sv -----
// Back end: column memories, load, filter and evaluate sequencing, result registers.
module acf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  acf_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  acf_pkg::item_t                q_item,
  output logic                          q_take,
  output logic                          out_valid,
  output logic                          kind,
  output logic [7:0]                    out_symbol,
  output logic [acf_pkg::COUNT_W-1:0]   const_a,
  output logic [acf_pkg::COUNT_W-1:0]   const_t,
  output logic [acf_pkg::COUNT_W-1:0]   const_c,
  output logic [acf_pkg::COUNT_W-1:0]   const_g,
  output logic [acf_pkg::COUNT_W-1:0]   kept_columns,
  output logic                          column_overflow
);
  import acf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_FILT  = 3'd2;
  localparam logic [2:0] ST_EPREP = 3'd3;
  localparam logic [2:0] ST_ERUN  = 3'd4;
  localparam logic [2:0] ST_EOUT  = 3'd5;

  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_COLUMNS);

  // Column memories
  logic [TALLY_W-1:0] tally_mem [MAX_COLUMNS];
  logic [3:0]         bases_mem [MAX_COLUMNS];
  logic               keep_mem  [MAX_COLUMNS];
  logic [TALLY_W-1:0] tally_q;
  logic [3:0]         bases_q;
  logic               keep_q;
  logic [ADDR_W-1:0]  rd_addr;

  logic [2:0]         state;
  item_t              cur;
  logic [COL_W-1:0]   col;
  logic [COL_W-1:0]   len;
  logic [COL_W-1:0]   wcol;
  logic               fresh;
  logic [RC_W-1:0]    rc;
  logic               in_rec;
  logic               ovf;
  logic [PROD_W-1:0]  prod;
  logic [COL_W-1:0]   eidx;
  logic               v1;
  logic [ADDR_W-1:0]  idx1;
  logic [COUNT_W-1:0] cnt [4];
  logic [COUNT_W-1:0] kept;

  // Load read-modify-write values
  logic [TALLY_W-1:0] t_old;
  logic [3:0]         b_old;
  logic [TALLY_W-1:0] t_new;
  logic [COL_W-1:0]   col_inc;

  // Evaluate decision for the column in the read stage
  logic [PROD_W-1:0]  inv_scaled;
  logic               under_limit;
  logic               multi;
  logic               single;
  logic [1:0]         single_idx;
  logic               keep_now;

  assign q_take = (state == ST_IDLE) && q_valid;

  always_comb begin
    t_old   = fresh ? '0 : tally_q;
    b_old   = fresh ? '0 : bases_q;
    t_new   = (cur.invalid && (t_old != TALLY_MAX)) ? t_old + 1'b1 : t_old;
    col_inc = wcol + 1'b1;
  end

  always_comb begin
    inv_scaled  = PROD_W'(tally_q) * PROD_W'(SCALE);
    under_limit = inv_scaled <= prod;
    multi       = !$onehot0(bases_q);
    single      = $onehot(bases_q);
    case (bases_q)
      4'b0001: single_idx = 2'd0;
      4'b0010: single_idx = 2'd1;
      4'b0100: single_idx = 2'd2;
      4'b1000: single_idx = 2'd3;
      default: single_idx = 2'd0;
    endcase
    keep_now = under_limit && (!cfg.snp_only || multi);
  end

  // Read address: current column when idle, walk index during evaluate
  assign rd_addr = (state == ST_ERUN) ? eidx[ADDR_W-1:0] : col[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    tally_q <= tally_mem[rd_addr];
    if (state == ST_LOAD) begin
      tally_mem[wcol[ADDR_W-1:0]] <= t_new;
    end
  end

  always_ff @(posedge clk) begin
    bases_q <= bases_mem[rd_addr];
    if (state == ST_LOAD) begin
      bases_mem[wcol[ADDR_W-1:0]] <= b_old | cur.base;
    end
  end

  always_ff @(posedge clk) begin
    keep_q <= keep_mem[rd_addr];
    if (state == ST_ERUN && v1) begin
      keep_mem[idx1] <= keep_now;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col       <= '0;
      len       <= '0;
      rc        <= '0;
      in_rec    <= 1'b0;
      ovf       <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
      kept      <= '0;
      for (int i = 0; i < 4; i++) cnt[i] <= '0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            case (q_item.op)
              OP_LOAD_SYM: begin
                if (in_rec) begin
                  if (col >= COL_LIMIT) begin
                    ovf <= 1'b1;
                  end else begin
                    wcol  <= col;
                    fresh <= (col >= len);
                    state <= ST_LOAD;
                  end
                end
              end
              OP_LOAD_HDR: begin
                if (rc != RC_W'(MAX_RECORDS)) rc <= rc + 1'b1;
                col    <= '0;
                in_rec <= 1'b1;
              end
              OP_EVALUATE: state <= ST_EPREP;
              OP_FILT_SYM: begin
                if (in_rec) begin
                  wcol  <= col;
                  if (col < COL_LIMIT) col <= col + 1'b1;
                  state <= ST_FILT;
                end
              end
              OP_FILT_HDR: begin
                col    <= '0;
                in_rec <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          col <= col_inc;
          if (col_inc > len) len <= col_inc;
          state <= ST_IDLE;
        end
        ST_FILT: begin
          if ((wcol < len) && keep_q) begin
            out_valid       <= 1'b1;
            kind            <= 1'b0;
            out_symbol      <= cur.sym;
            const_a         <= '0;
            const_t         <= '0;
            const_c         <= '0;
            const_g         <= '0;
            kept_columns    <= '0;
            column_overflow <= 1'b0;
          end
          state <= ST_IDLE;
        end
        ST_EPREP: begin
          prod  <= (cfg.drop_invalid ? '0 : PROD_W'(cfg.invalid_limit)) * PROD_W'(rc);
          kept  <= '0;
          for (int i = 0; i < 4; i++) cnt[i] <= '0;
          eidx  <= '0;
          v1    <= 1'b0;
          state <= ST_ERUN;
        end
        ST_ERUN: begin
          // issue stage
          if (eidx < len) begin
            idx1 <= eidx[ADDR_W-1:0];
            eidx <= eidx + 1'b1;
            v1   <= 1'b1;
          end else begin
            v1 <= 1'b0;
            if (!v1) state <= ST_EOUT;
          end
          // decide stage
          if (v1) begin
            if (keep_now && (kept != COUNT_MAX)) kept <= kept + 1'b1;
            if (cfg.report_constant && (tally_q == '0) && single &&
                (cnt[single_idx] != COUNT_MAX)) begin
              cnt[single_idx] <= cnt[single_idx] + 1'b1;
            end
          end
        end
        ST_EOUT: begin
          out_valid       <= 1'b1;
          kind            <= 1'b1;
          out_symbol      <= '0;
          const_a         <= cnt[0];
          const_t         <= cnt[1];
          const_c         <= cnt[2];
          const_g         <= cnt[3];
          kept_columns    <= kept;
          column_overflow <= ovf;
          state           <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_summary: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EOUT) |=> (out_valid && kind)) else $error("summary not issued");
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (len <= COL_LIMIT) && (col <= COL_LIMIT)) else $error("column index out of range");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ERUN && v1) |-> (COL_W'(idx1) < len)) else $error("walk past length");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |=> !(state == ST_IDLE && $past(q_item.op) == OP_EVALUATE))
    else $error("evaluate not started");

endmodule

// ----- sv/alignment_column_filter.sv -----
// Alignment column filter top level: configuration registers, front and back ends.
// Header and ignored symbols are handled in the idle state; loads and filter symbols also pass
// through a second state (memory read then write or decide), from which a filter result is registered.
// Evaluate passes through prepare, walk and output states, one column read per cycle.
// A 4-entry queue holds commands; busy is high while it is full. Results cannot stall.
// Synchronous reset clears control state; column memories need no clearing pass.
module alignment_column_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    operation,
  input  logic [7:0]                    symbol,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [acf_pkg::LIMIT_W-1:0]   cfg_data,
  output logic                          out_valid,
  output logic                          kind,
  output logic [7:0]                    out_symbol,
  output logic [acf_pkg::COUNT_W-1:0]   const_a,
  output logic [acf_pkg::COUNT_W-1:0]   const_t,
  output logic [acf_pkg::COUNT_W-1:0]   const_c,
  output logic [acf_pkg::COUNT_W-1:0]   const_g,
  output logic [acf_pkg::COUNT_W-1:0]   kept_columns,
  output logic                          column_overflow
);
  import acf_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_take;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invalid_limit   <= LIMIT_RESET;
      cfg.drop_invalid    <= 1'b0;
      cfg.snp_only        <= 1'b0;
      cfg.report_constant <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIMIT:  cfg.invalid_limit   <= cfg_data;
        REG_STRICT: cfg.drop_invalid    <= cfg_data[0];
        REG_SNP:    cfg.snp_only        <= cfg_data[0];
        REG_CONST:  cfg.report_constant <= cfg_data[0];
        default: ;
      endcase
    end
  end

  acf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .symbol    (symbol),
    .busy      (busy),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take)
  );

  acf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_take          (q_take),
    .out_valid       (out_valid),
    .kind            (kind),
    .out_symbol      (out_symbol),
    .const_a         (const_a),
    .const_t         (const_t),
    .const_c         (const_c),
    .const_g         (const_g),
    .kept_columns    (kept_columns),
    .column_overflow (column_overflow)
  );

endmodule

// ----- dv/alignment_column_filter_tb.sv -----
// Self-checking testbench for the alignment column filter: loads, evaluate and filter passes.
`timescale 1ns / 1ps

module alignment_column_filter_tb;
  import acf_pkg::*;

  // Operation codes the block ignores
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {W_CMD, W_CFG, W_PAUSE} work_kind_e;

  typedef struct {
    work_kind_e          wk;
    logic [2:0]          op;
    logic [7:0]          sym;
    logic [1:0]          idx;
    logic [LIMIT_W-1:0]  data;
    int                  cycles;
  } work_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         sym;
    logic [COUNT_W-1:0] ca, ct, cc, cg, kept;
    logic               ovf;
  } summary_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] operation = OP_LOAD_HDR;
  logic [7:0] symbol = 8'd0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_LIMIT;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, out_valid, kind, column_overflow;
  logic [7:0] out_symbol;
  logic [COUNT_W-1:0] const_a, const_t, const_c, const_g, kept_columns;

  alignment_column_filter u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .symbol(symbol),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .kind(kind), .out_symbol(out_symbol),
    .const_a(const_a), .const_t(const_t), .const_c(const_c), .const_g(const_g),
    .kept_columns(kept_columns), .column_overflow(column_overflow)
  );

  always #5 clk = ~clk;

  work_t    pending[$];
  summary_t expected_out[$];
  int       errors = 0;
  bit       stim_done = 1'b0;

  // Column model state
  bit [15:0] inv_tally[MAX_COLUMNS];
  bit [3:0]  base_mask[MAX_COLUMNS];
  bit        keep_col[MAX_COLUMNS];
  int        rec_cnt = 0, col_pos = 0, aln_len = 0, ovf_flag = 0;
  bit        in_rec = 1'b0;
  int        lim_reg = 500;
  bit        strict_reg = 1'b0, snp_reg = 1'b0, const_reg = 1'b0;

  function automatic int base_index(logic [7:0] s);
    case (s)
      CH_A: return 0;
      CH_T: return 1;
      CH_C: return 2;
      CH_G: return 3;
      default: return -1;
    endcase
  endfunction

  // Walk all columns, rebuild keep mask and the summary
  function automatic summary_t evaluate_columns();
    summary_t r;
    int cnt[4];
    int kept, n, last;
    longint lim;
    bit keep;
    cnt = '{0, 0, 0, 0};
    kept = 0;
    lim = strict_reg ? 0 : lim_reg;
    for (int i = 0; i < aln_len; i++) begin
      n = 0;
      last = 0;
      for (int j = 0; j < 4; j++)
        if (base_mask[i][j]) begin
          n++;
          last = j;
        end
      keep = (longint'(inv_tally[i]) * 10000) <= lim * rec_cnt;
      if (snp_reg && n < 2) keep = 0;
      keep_col[i] = keep;
      if (keep && kept < COUNT_MAX) kept++;
      if (const_reg && inv_tally[i] == 0 && n == 1 && cnt[last] < COUNT_MAX) cnt[last]++;
    end
    r.kind = 1'b1;
    r.sym = '0;
    r.ca = COUNT_W'(cnt[0]);
    r.ct = COUNT_W'(cnt[1]);
    r.cc = COUNT_W'(cnt[2]);
    r.cg = COUNT_W'(cnt[3]);
    r.kept = COUNT_W'(kept);
    r.ovf = ovf_flag[0];
    return r;
  endfunction

  // Apply one accepted command, queue any result it causes
  task automatic predict_command(logic [2:0] op, logic [7:0] sym);
    summary_t r;
    int c, k;
    c = col_pos;
    case (op)
      OP_LOAD_SYM: if (in_rec) begin
        if (c >= MAX_COLUMNS) ovf_flag = 1;
        else begin
          if (sym == CH_N || sym == CH_GAP) begin
            if (inv_tally[c] != 16'hFFFF) inv_tally[c]++;
          end else begin
            k = base_index(sym);
            if (k >= 0) base_mask[c][k] = 1'b1;
          end
          col_pos++;
          if (col_pos > aln_len) aln_len = col_pos;
        end
      end
      OP_LOAD_HDR: begin
        if (rec_cnt < MAX_RECORDS) rec_cnt++;
        col_pos = 0;
        in_rec = 1'b1;
      end
      OP_EVALUATE: expected_out.push_back(evaluate_columns());
      OP_FILT_SYM: if (in_rec) begin
        if (col_pos < MAX_COLUMNS) col_pos++;
        if (c < aln_len && keep_col[c]) begin
          r = '{1'b0, sym, '0, '0, '0, '0, '0, 1'b0};
          expected_out.push_back(r);
        end
      end
      OP_FILT_HDR: begin
        col_pos = 0;
        in_rec = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Checker and predictor: results first so a fresh expectation is never matched early
  logic cmd_fire = 1'b0, cfg_fire = 1'b0;
  summary_t got, exp_r;
  always @(posedge clk) begin
    cmd_fire <= start && !busy && !rst;
    cfg_fire <= cfg_valid && cfg_ready && !rst;
    if (!rst) begin
      if (out_valid) begin
        got = '{kind, out_symbol, const_a, const_t, const_c, const_g, kept_columns,
                column_overflow};
        if (expected_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind=%0d sym=%h", $time, kind, out_symbol);
        end else begin
          exp_r = expected_out.pop_front();
          if (got !== exp_r) begin
            errors++;
            $display("%0t: expected kind=%0d sym=%h a=%0d t=%0d c=%0d g=%0d kept=%0d ovf=%0d",
                     $time, exp_r.kind, exp_r.sym, exp_r.ca, exp_r.ct, exp_r.cc, exp_r.cg,
                     exp_r.kept, exp_r.ovf);
            $display("%0t: actual   kind=%0d sym=%h a=%0d t=%0d c=%0d g=%0d kept=%0d ovf=%0d",
                     $time, got.kind, got.sym, got.ca, got.ct, got.cc, got.cg,
                     got.kept, got.ovf);
          end
        end
      end
      if (start && !busy) predict_command(operation, symbol);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIMIT:  lim_reg = int'(cfg_data);
          REG_STRICT: strict_reg = cfg_data[0];
          REG_SNP:    snp_reg = cfg_data[0];
          REG_CONST:  const_reg = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Driver: one transfer at a time, inputs change on the falling edge
  int   pops = 0, pause_left = 0;
  bit   pausing = 1'b0;
  work_t w;
  always @(negedge clk) begin
    if (!rst) begin
      if ((start && !cmd_fire) || (cfg_valid && !cfg_fire)) begin
        // hold current transfer
      end else if (pausing) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        if (expected_out.size() == 0) begin
          if (pause_left == 0) pausing = 1'b0;
          else pause_left--;
        end
      end else if (pending.size() == 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        stim_done = 1'b1;
      end else if ((pops < 300 || pops > 700) && $urandom_range(99) < 11) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        w = pending.pop_front();
        pops++;
        start <= (w.wk == W_CMD);
        cfg_valid <= (w.wk == W_CFG);
        if (w.wk == W_CMD) begin
          operation <= w.op;
          symbol <= w.sym;
        end else if (w.wk == W_CFG) begin
          cfg_index <= w.idx;
          cfg_data <= w.data;
        end else begin
          pausing = 1'b1;
          pause_left = w.cycles;
        end
      end
    end
  end

  task automatic push_cmd(logic [2:0] op, logic [7:0] sym);
    pending.push_back('{W_CMD, op, sym, REG_LIMIT, '0, 0});
  endtask

  task automatic push_cfg(logic [1:0] idx, logic [LIMIT_W-1:0] data);
    pending.push_back('{W_PAUSE, OP_LOAD_HDR, 8'd0, REG_LIMIT, '0, 200});
    pending.push_back('{W_CFG, OP_LOAD_HDR, 8'd0, idx, data, 0});
  endtask

  task automatic push_pause(int n);
    pending.push_back('{W_PAUSE, OP_LOAD_HDR, 8'd0, REG_LIMIT, '0, n});
  endtask

  // Mostly bases, some invalid marks, some arbitrary bytes
  function automatic logic [7:0] pick_symbol();
    int r;
    logic [7:0] bases[4];
    bases = '{CH_A, CH_T, CH_C, CH_G};
    r = $urandom_range(99);
    if (r < 70) return bases[$urandom_range(3)];
    if (r < 85) return $urandom_range(1) ? CH_N : CH_GAP;
    return 8'($urandom_range(255));
  endfunction

  // Random settings, extremes weighted in
  task automatic random_config();
    int r;
    logic [LIMIT_W-1:0] lim;
    r = $urandom_range(5);
    case (r)
      0: lim = '0;
      1: lim = LIMIT_W'(1);
      2: lim = LIMIT_W'(10000);
      3: lim = {LIMIT_W{1'b1}};
      4: lim = LIMIT_W'(500);
      default: lim = LIMIT_W'($urandom_range(16383));
    endcase
    push_cfg(REG_LIMIT, lim);
    push_cfg(REG_STRICT, LIMIT_W'($urandom_range(3) == 0));
    push_cfg(REG_SNP, LIMIT_W'($urandom_range(1)));
    push_cfg(REG_CONST, LIMIT_W'($urandom_range(2) != 0));
  endtask

  // Load a block of records, evaluate, re-send them through the filter
  task automatic alignment_phase(ref int count);
    logic [7:0] recs[$][$];
    logic [7:0] one[$];
    int nrec, len, base_len;
    nrec = $urandom_range(2, 6);
    base_len = $urandom_range(1, 40);
    for (int r = 0; r < nrec; r++) begin
      one.delete();
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : base_len;
      for (int i = 0; i < len; i++) one.push_back(pick_symbol());
      recs.push_back(one);
    end
    foreach (recs[r]) begin
      push_cmd(OP_LOAD_HDR, 8'($urandom_range(255)));
      foreach (recs[r][i]) push_cmd(OP_LOAD_SYM, recs[r][i]);
    end
    push_cmd(OP_EVALUATE, 8'($urandom_range(255)));
    foreach (recs[r]) begin
      push_cmd(OP_FILT_HDR, 8'($urandom_range(255)));
      foreach (recs[r][i])
        push_cmd(OP_FILT_SYM, $urandom_range(4) == 0 ? 8'($urandom_range(255)) : recs[r][i]);
      // broken record: runs past the end of the alignment
      if ($urandom_range(5) == 0)
        repeat ($urandom_range(1, 8)) push_cmd(OP_FILT_SYM, 8'($urandom_range(255)));
    end
    if ($urandom_range(3) == 0) push_cmd(OP_EVALUATE, 8'd0);
    foreach (recs[r]) count += 2 * (recs[r].size() + 1);
  endtask

  // Noise: random commands other than filtering, closed by an evaluate
  task automatic noise_phase(ref int count);
    int n;
    logic [2:0] ops[6];
    ops = '{OP_LOAD_SYM, OP_LOAD_HDR, OP_EVALUATE, OP_SPARE_5, OP_SPARE_6, OP_SPARE_7};
    n = $urandom_range(5, 20);
    repeat (n) push_cmd(ops[$urandom_range(5)], 8'($urandom_range(255)));
    push_cmd(OP_EVALUATE, 8'($urandom_range(255)));
    count += n + 1;
  endtask

  initial begin
    int count;
    string seq;
    // Directed: symbols before any header, empty evaluate, unused codes
    push_cmd(OP_LOAD_SYM, CH_A);
    push_cmd(OP_FILT_SYM, CH_G);
    push_cmd(OP_EVALUATE, 8'hFF);
    push_cmd(OP_SPARE_5, 8'h00);
    push_cmd(OP_SPARE_6, 8'hAA);
    push_cmd(OP_SPARE_7, 8'h55);
    push_cfg(REG_LIMIT, {LIMIT_W{1'b1}});
    push_cfg(REG_STRICT, LIMIT_W'(1'b0));
    push_cfg(REG_SNP, LIMIT_W'(1'b0));
    push_cfg(REG_CONST, LIMIT_W'(1'b1));
    // Two records: constant, variable, invalid and odd-byte columns
    push_cmd(OP_LOAD_HDR, 8'h00);
    seq = "ATCGN-a";
    for (int i = 0; i < seq.len(); i++) push_cmd(OP_LOAD_SYM, seq[i]);
    push_cmd(OP_LOAD_HDR, 8'h00);
    push_cmd(OP_LOAD_SYM, CH_A);
    push_cmd(OP_LOAD_SYM, CH_T);
    push_cmd(OP_LOAD_SYM, CH_G);
    push_cmd(OP_LOAD_SYM, 8'h00);
    push_cmd(OP_LOAD_SYM, CH_GAP);
    push_cmd(OP_EVALUATE, 8'h00);
    push_cmd(OP_FILT_HDR, 8'h00);
    repeat (7) push_cmd(OP_FILT_SYM, 8'hFF);
    push_cmd(OP_EVALUATE, 8'h00);

    // Random part
    count = 0;
    while (count < 1050) begin
      if ($urandom_range(2) == 0) random_config();
      if ($urandom_range(4) == 0) noise_phase(count);
      else alignment_phase(count);
    end
    push_pause(200);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_out.size() == 0 && !start);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("alignment_column_filter: match");
    end else begin
      $display("alignment_column_filter: mismatch");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("alignment_column_filter: mismatch");
    $finish;
  end

endmodule

// ----- alignment_column_filter.f -----
sv/acf_pkg.sv
sv/acf_front.sv
sv/acf_back.sv
sv/alignment_column_filter.sv
dv/alignment_column_filter_tb.sv
